[rtl/core/page_replacement_engine_macros.svh]
// Assertion macros for the page replacement engine.
// No dependencies; taken in by the top level.
`ifndef PAGE_REPLACEMENT_ENGINE_MACROS_SVH
`define PAGE_REPLACEMENT_ENGINE_MACROS_SVH
// implication check on the rising clock edge, disabled during reset
`define PRE_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication check
`define PRE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

[rtl/core/pre_pkg.sv]
// Package for the page replacement engine: types, constants and codes.
// No dependencies.
package pre_pkg;
   localparam int FRAMES_DEF     = 64;
   localparam int PAGE_BYTES_DEF = 4096;
   localparam int PAGE_W         = 20;
   localparam int STAMP_W        = 32;
   localparam int COUNT_W        = 32;

   typedef enum logic [1:0] {
      MODE_FIFO = 2'd0,
      MODE_LRU  = 2'd1,
      MODE_SEG  = 2'd2,
      MODE_RSVD = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CSR_MODE    = 2'd0,
      CSR_FRAMES  = 2'd1,
      CSR_PERCENT = 2'd2
   } csr_index_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE,
      ST_EVICT_RD,
      ST_EVICT_WAIT,
      ST_DEMOTE,
      ST_DEMOTE_WAIT,
      ST_INSERT,
      ST_DONE
   } state_type;
endpackage

[rtl/core/pre_ram.sv]
// Generic single-port write, single read-port synchronous RAM.
// Registered read data; no dependencies.
module pre_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

[rtl/core/page_replacement_engine.sv]
// Page replacement engine top level: frame store in RAM, flag bits and a
// scanning sequencer. Depends on pre_pkg, pre_ram and the macros header.
//
// Usage: one request (req_type, req_byte_address) enters on the req_ valid/ready
// channel; one response with hit/fault, dirty write-back, victim page and
// saturating totals leaves on the rsp_ channel. The csr_ port writes mode,
// frames in use and secondary percent; the user must write it only while the
// block is idle, as the block itself does not enforce this. Each request is a
// scan of all FRAMES entries of the page/stamp RAM, one entry per cycle, then
// a decide step, an eviction read, a demotion read-modify-write and an
// insertion, after which the response is registered. A new request is taken
// only in the idle state, so the block works on one request at a time.
// The response sits in an output register; req_ready rises again only once
// the response has been taken, so a stalled receiver holds the block.
// Reset clears valid, dirty and secondary bits, the access clock and totals,
// and restores fifo mode, 64 frames and zero percent; RAM contents need no
// clearing as entries are read only when their valid bit is set.
`include "page_replacement_engine_macros.svh"
module page_replacement_engine
   import pre_pkg::*;
#(
   parameter int FRAMES     = FRAMES_DEF,
   parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_type,
   input  logic [31:0]         req_byte_address,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_hit,
   output logic                rsp_fault,
   output logic                rsp_disk_write,
   output logic                rsp_victim_valid,
   output logic [PAGE_W-1:0]   rsp_victim_page,
   output logic [COUNT_W-1:0]  rsp_hit_total,
   output logic [COUNT_W-1:0]  rsp_fault_total,
   output logic [COUNT_W-1:0]  rsp_write_total,
   input  logic                csr_write,
   input  logic [1:0]          csr_index,
   input  logic [6:0]          csr_data
);
   localparam int IW     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int CW     = $clog2(FRAMES + 1);
   localparam int SHIFT  = $clog2(PAGE_BYTES);
   localparam int PG_W   = 32 - SHIFT;
   localparam int ENT_W  = PG_W + STAMP_W;
   // divide by 100 as a multiply by ceil(2^27 / 100) and a shift
   localparam int RECIP_SHIFT = 27;
   localparam logic [20:0] RECIP_100 = 21'd1342178;

   // configuration
   logic [1:0] mode_ff;
   logic [6:0] frames_ff, pct_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_FIFO;
         frames_ff <= 7'd64;
         pct_ff    <= 7'd0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MODE:    mode_ff   <= csr_data[1:0];
            CSR_FRAMES:  frames_ff <= csr_data;
            CSR_PERCENT: pct_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // effective frame split
   logic [12:0] n_eff;
   logic [6:0]  p_eff;
   logic [19:0] np_in, np_ff;
   logic [40:0] sec_prod;
   logic [12:0] sec_n, prim_n;
   always_comb begin
      n_eff = {6'd0, frames_ff};
      if (frames_ff == 7'd0) n_eff = 13'd1;
      if (n_eff > 13'(FRAMES)) n_eff = 13'(FRAMES);
      p_eff    = (pct_ff > 7'd100) ? 7'd100 : pct_ff;
      np_in    = 20'(n_eff) * 20'(p_eff);
      sec_prod = 41'(np_ff) * 41'(RECIP_100);
      sec_n    = 13'(sec_prod >> RECIP_SHIFT);
      prim_n   = n_eff - sec_n;
   end

   // hold the frames-by-percent product; settles long before any decision
   always_ff @(posedge clock) begin
      if (reset) np_ff <= '0;
      else       np_ff <= np_in;
   end

   // per-frame flags in flip-flops
   logic [FRAMES-1:0] valid_ff, dirty_ff, sec_ff;

   // frame RAM: page and stamp
   logic            ram_we;
   logic [IW-1:0]   ram_wa, ram_ra;
   logic [ENT_W-1:0] ram_wd, ram_rd;
   pre_ram #(.WIDTH(ENT_W), .DEPTH(FRAMES)) u_frame_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );
   logic [PG_W-1:0]    rd_page;
   logic [STAMP_W-1:0] rd_stamp;
   assign rd_page  = ram_rd[ENT_W-1:STAMP_W];
   assign rd_stamp = ram_rd[STAMP_W-1:0];

   state_type state_ff, state_in;

   // request and scan registers
   logic               wr_ff;
   logic [PG_W-1:0]    page_ff;
   logic [STAMP_W-1:0] clk_ff, clk_in;
   logic [IW:0]        scan_ff;          // address issued
   logic               rdv_ff;           // read data valid
   logic [IW-1:0]      rdi_ff;           // index of read data
   logic               hit_ff;
   logic [IW-1:0]      hidx_ff;
   // oldest trackers: any, primary, secondary, second oldest primary
   logic               oa_v_ff, op_v_ff, os_v_ff, ox_v_ff;
   logic [IW-1:0]      oa_i_ff, op_i_ff, os_i_ff, ox_i_ff;
   logic [STAMP_W-1:0] oa_s_ff, op_s_ff, os_s_ff, ox_s_ff;
   logic [CW-1:0]      pc_ff, sc_ff, ac_ff;
   logic               ffree_v_ff;
   logic [IW-1:0]      ffree_i_ff;
   // actions
   logic               ev_v_ff, ev_d_ff;
   logic [IW-1:0]      ev_i_ff;
   logic [PG_W-1:0]    ev_pg_ff;
   logic               dem_v_ff;
   logic [IW-1:0]      dem_i_ff;
   logic               ins_ff;

   // response registers
   logic               rsp_v_ff;
   logic               o_hit_ff, o_dw_ff, o_vv_ff;
   logic [PAGE_W-1:0]  o_vp_ff;
   logic [COUNT_W-1:0] hcnt_ff, fcnt_ff, wcnt_ff;

   logic seg_mode, lru_mode;
   always_comb begin
      lru_mode = (mode_ff == MODE_LRU) || (mode_ff == MODE_SEG && prim_n == 13'd0);
      seg_mode = (mode_ff == MODE_SEG) && prim_n != 13'd0 && sec_n != 13'd0;
   end

   assign req_ready = (state_ff == ST_IDLE) && !rsp_v_ff;
   logic accept;
   assign accept = req_valid && req_ready;
   assign clk_in = clk_ff + 1'b1;

   // next state
   logic scan_last;
   assign scan_last = (scan_ff == (IW+1)'(FRAMES));
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:        if (accept) state_in = ST_SCAN;
         ST_SCAN:        if (scan_last) state_in = ST_DRAIN;
         ST_DRAIN:       state_in = ST_DECIDE;
         ST_DECIDE:      state_in = ST_EVICT_RD;
         ST_EVICT_RD:    state_in = ST_EVICT_WAIT;
         ST_EVICT_WAIT:  state_in = ST_DEMOTE;
         ST_DEMOTE:      state_in = ST_DEMOTE_WAIT;
         ST_DEMOTE_WAIT: state_in = ST_INSERT;
         ST_INSERT:      state_in = ST_DONE;
         ST_DONE:        state_in = ST_IDLE;
         default:        state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // outputs of the sequencer: RAM port
   always_comb begin
      ram_we = 1'b0;
      ram_wa = hidx_ff;
      ram_wd = {page_ff, clk_ff};
      ram_ra = scan_ff[IW-1:0];
      unique case (state_ff)
         ST_EVICT_RD: ram_ra = ev_i_ff;
         ST_DEMOTE: begin
            // read address only; the hit stamp is written in decide, the demoted one below
            ram_ra = ev_i_ff;
         end
         ST_INSERT: begin
            ram_we = ins_ff;
            ram_wa = ffree_i_ff;
            ram_wd = {page_ff, clk_ff};
         end
         default: ;
      endcase
      if (state_ff == ST_DECIDE && hit_ff && (lru_mode || (seg_mode && sec_ff[hidx_ff]))) begin
         ram_we = 1'b1;
         ram_wa = hidx_ff;
         ram_wd = {page_ff, clk_ff};
      end
      if (state_ff == ST_DEMOTE && dem_v_ff) begin
         ram_we = 1'b1;
         ram_wa = dem_i_ff;
         ram_wd = {ram_rd[ENT_W-1:STAMP_W], clk_ff};
      end
      if (state_ff == ST_EVICT_WAIT && dem_v_ff) ram_ra = dem_i_ff;
   end

   // scan bookkeeping and decisions
   logic          ev_go;
   logic [CW-1:0] lim_any;
   always_comb begin
      lim_any = CW'(n_eff);
      ev_go   = 1'b0;
      if (seg_mode)
         ev_go = (pc_ff >= CW'(prim_n) && sc_ff >= CW'(sec_n)) || !ffree_v_ff;
      else
         ev_go = (ac_ff >= lim_any) || !ffree_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         dirty_ff <= '0;
         sec_ff   <= '0;
         clk_ff   <= '0;
         hcnt_ff  <= '0;
         fcnt_ff  <= '0;
         wcnt_ff  <= '0;
         rsp_v_ff <= 1'b0;
      end else begin
         if (rsp_v_ff && rsp_ready) rsp_v_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: if (accept) begin
               clk_ff     <= clk_in;
               wr_ff      <= req_type;
               page_ff    <= req_byte_address[31:SHIFT];
               scan_ff    <= '0;
               rdv_ff     <= 1'b0;
               hit_ff     <= 1'b0;
               oa_v_ff    <= 1'b0; op_v_ff <= 1'b0; os_v_ff <= 1'b0; ox_v_ff <= 1'b0;
               pc_ff      <= '0; sc_ff <= '0; ac_ff <= '0;
               ffree_v_ff <= 1'b0;
               ev_v_ff    <= 1'b0; ev_d_ff <= 1'b0; ev_pg_ff <= '0;
               dem_v_ff   <= 1'b0;
               ins_ff     <= 1'b0;
            end
            ST_SCAN, ST_DRAIN: begin
               if (state_ff == ST_SCAN) scan_ff <= scan_ff + 1'b1;
               rdv_ff <= (state_ff == ST_SCAN) && !scan_last;
               rdi_ff <= scan_ff[IW-1:0];
               if (rdv_ff) begin
                  if (!valid_ff[rdi_ff]) begin
                     if (!ffree_v_ff) begin
                        ffree_v_ff <= 1'b1;
                        ffree_i_ff <= rdi_ff;
                     end
                  end else begin
                     ac_ff <= ac_ff + 1'b1;
                     if (rd_page == page_ff) begin
                        hit_ff  <= 1'b1;
                        hidx_ff <= rdi_ff;
                     end
                     if (!oa_v_ff || rd_stamp < oa_s_ff) begin
                        oa_v_ff <= 1'b1; oa_i_ff <= rdi_ff; oa_s_ff <= rd_stamp;
                     end
                     if (sec_ff[rdi_ff]) begin
                        sc_ff <= sc_ff + 1'b1;
                        if (!os_v_ff || rd_stamp < os_s_ff) begin
                           os_v_ff <= 1'b1; os_i_ff <= rdi_ff; os_s_ff <= rd_stamp;
                        end
                     end else begin
                        pc_ff <= pc_ff + 1'b1;
                        // keep the two oldest primary entries
                        if (!op_v_ff || rd_stamp < op_s_ff) begin
                           op_v_ff <= 1'b1; op_i_ff <= rdi_ff; op_s_ff <= rd_stamp;
                           ox_v_ff <= op_v_ff; ox_i_ff <= op_i_ff; ox_s_ff <= op_s_ff;
                        end else if (!ox_v_ff || rd_stamp < ox_s_ff) begin
                           ox_v_ff <= 1'b1; ox_i_ff <= rdi_ff; ox_s_ff <= rd_stamp;
                        end
                     end
                  end
               end
            end
            ST_DECIDE: begin
               if (hit_ff) begin
                  if (wr_ff) dirty_ff[hidx_ff] <= 1'b1;
                  if (!seg_mode) sec_ff[hidx_ff] <= 1'b0;
                  else if (sec_ff[hidx_ff]) begin
                     sec_ff[hidx_ff] <= 1'b0;
                     // demote oldest primary excluding hit: primary oldest
                     // is never the hit since the hit is secondary
                     if (pc_ff >= CW'(prim_n) && op_v_ff) begin
                        dem_v_ff <= 1'b1;
                        dem_i_ff <= op_i_ff;
                     end
                  end
               end else begin
                  ins_ff <= 1'b1;
                  if (ev_go) begin
                     ev_v_ff <= 1'b1;
                     if (!seg_mode) ev_i_ff <= oa_i_ff;
                     else if (sc_ff != '0) ev_i_ff <= os_i_ff;
                     else ev_i_ff <= op_i_ff;
                  end
                  if (seg_mode) begin
                     if (ev_go && sc_ff == '0) begin
                        // oldest primary leaves; demote the next oldest
                        if (pc_ff != '0 && (pc_ff - 1'b1) >= CW'(prim_n) && ox_v_ff) begin
                           dem_v_ff <= 1'b1;
                           dem_i_ff <= ox_i_ff;
                        end
                     end else if (pc_ff >= CW'(prim_n) && op_v_ff) begin
                        dem_v_ff <= 1'b1;
                        dem_i_ff <= op_i_ff;
                     end
                  end
               end
            end
            ST_EVICT_RD: ;
            ST_EVICT_WAIT: begin
               if (ev_v_ff) begin
                  ev_d_ff  <= dirty_ff[ev_i_ff];
                  ev_pg_ff <= rd_page;
                  valid_ff[ev_i_ff] <= 1'b0;
                  dirty_ff[ev_i_ff] <= 1'b0;
                  sec_ff[ev_i_ff]   <= 1'b0;
                  // the lowest free frame takes the new page
                  if (!ffree_v_ff || ev_i_ff < ffree_i_ff) begin
                     ffree_v_ff <= 1'b1;
                     ffree_i_ff <= ev_i_ff;
                  end
               end
            end
            ST_DEMOTE: begin
               if (dem_v_ff) sec_ff[dem_i_ff] <= 1'b1;
            end
            ST_DEMOTE_WAIT: ;
            ST_INSERT: begin
               if (ins_ff && ffree_v_ff) begin
                  valid_ff[ffree_i_ff] <= 1'b1;
                  dirty_ff[ffree_i_ff] <= wr_ff;
                  sec_ff[ffree_i_ff]   <= 1'b0;
               end
            end
            ST_DONE: begin
               rsp_v_ff <= 1'b1;
               o_hit_ff <= hit_ff;
               o_vv_ff  <= ev_v_ff;
               o_dw_ff  <= ev_v_ff && ev_d_ff;
               o_vp_ff  <= ev_v_ff ? PAGE_W'(ev_pg_ff) : '0;
               if (hit_ff) begin
                  if (hcnt_ff != '1) hcnt_ff <= hcnt_ff + 1'b1;
               end else if (fcnt_ff != '1) begin
                  fcnt_ff <= fcnt_ff + 1'b1;
               end
               if (ev_v_ff && ev_d_ff && wcnt_ff != '1) wcnt_ff <= wcnt_ff + 1'b1;
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid        = rsp_v_ff;
   assign rsp_hit          = o_hit_ff;
   assign rsp_fault        = !o_hit_ff;
   assign rsp_disk_write   = o_dw_ff;
   assign rsp_victim_valid = o_vv_ff;
   assign rsp_victim_page  = o_vp_ff;
   assign rsp_hit_total    = hcnt_ff;
   assign rsp_fault_total  = fcnt_ff;
   assign rsp_write_total  = wcnt_ff;

   // checks
   `PRE_ASSERT_IMPL(a_ready_idle, clock, reset, req_ready, state_ff == ST_IDLE && !rsp_v_ff, "ready outside idle")
   `PRE_ASSERT_IMPL(a_victim_zero, clock, reset, rsp_v_ff && !o_vv_ff, o_vp_ff == '0 && !o_dw_ff, "victim fields without victim")
   `PRE_ASSERT_NEXT(a_accept_scan, clock, reset, accept, state_ff == ST_SCAN, "no scan after accept")
endmodule
